// File: hw/rtl/dcdd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcdd_pkg
// Shared types, constants and calendar functions for the date check and
// day difference block.
// ----------------------------------------------------------------------------
package dcdd_pkg;

    localparam int CALC_YEAR_BITS = 16;
    localparam int ORD_BITS       = 26;
    localparam int DIFF_BITS      = 22;
    localparam int STATUS_BITS    = 3;
    localparam int MAX_YEAR_BITS  = 14;

    localparam logic [MAX_YEAR_BITS-1:0] MAX_YEAR_RESET = 14'd2020;
    localparam logic [DIFF_BITS-1:0]     DIFF_MAX       = 22'd4194303;

    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] SECOND_MAX = 6'd59;

    // floor(x / 25) = (x * DIV25_MULT) >> DIV25_SHIFT, exact for 16-bit x
    localparam logic [17:0] DIV25_MULT  = 18'd167773;
    localparam int          DIV25_SHIFT = 22;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_VALID     = 3'd0,
        STATUS_DATE_ERR  = 3'd1,
        STATUS_TIME_ERR  = 3'd2,
        STATUS_BOTH_ERR  = 3'd3,
        STATUS_ZERO_DATE = 3'd4
    } status_t;

    typedef logic [CALC_YEAR_BITS-1:0] year_t;
    typedef logic [ORD_BITS-1:0]       ordinal_t;

    function automatic logic [CALC_YEAR_BITS-1:0] div25(input logic [CALC_YEAR_BITS-1:0] x);
        logic [33:0] prod;
        prod = 34'(x) * 34'(DIV25_MULT);
        return CALC_YEAR_BITS'(prod[33:DIV25_SHIFT]);
    endfunction

    function automatic logic is_leap(input year_t y);
        logic [CALC_YEAR_BITS-1:0] q;
        logic [CALC_YEAR_BITS+4:0] back;
        logic                      by25;
        q    = div25(y);
        back = (21'(q) << 4) + (21'(q) << 3) + 21'(q);
        by25 = (back == 21'(y));
        return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input year_t y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = is_leap(y) ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] n;
        case (m)
            4'd0, 4'd1: n = 9'd0;
            4'd2:       n = 9'd31;
            4'd3:       n = 9'd59;
            4'd4:       n = 9'd90;
            4'd5:       n = 9'd120;
            4'd6:       n = 9'd151;
            4'd7:       n = 9'd181;
            4'd8:       n = 9'd212;
            4'd9:       n = 9'd243;
            4'd10:      n = 9'd273;
            4'd11:      n = 9'd304;
            4'd12:      n = 9'd334;
            default:    n = 9'd365;
        endcase
        return n;
    endfunction

    // 365*y + leap years before y + day of year
    function automatic ordinal_t ordinal(input year_t y, input logic [3:0] m,
                                         input logic [4:0] d);
        logic [CALC_YEAR_BITS:0]   y3, y99, y399;
        logic [CALC_YEAR_BITS-1:0] c4, c100, c400;
        logic [CALC_YEAR_BITS:0]   leaps;
        ordinal_t                  n;
        y3    = 17'(y) + 17'd3;
        y99   = 17'(y) + 17'd99;
        y399  = 17'(y) + 17'd399;
        c4    = CALC_YEAR_BITS'(y3 >> 2);
        c100  = div25(CALC_YEAR_BITS'(y99 >> 2));
        c400  = div25(CALC_YEAR_BITS'(y399 >> 4));
        leaps = 17'(c4) - 17'(c100) + 17'(c400);
        n = ORD_BITS'(y) * ORD_BITS'(365) + ORD_BITS'(leaps)
            + ORD_BITS'(days_before_month(m)) + ORD_BITS'(d);
        if ((m > 4'd2) && is_leap(y)) begin
            n = n + ORD_BITS'(1);
        end
        return n;
    endfunction

endpackage

// File: hw/rtl/date_check_and_day_difference.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_check_and_day_difference
// An accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while m_tready keeps the result stage moving; the calendar check and
// both day ordinals are one combinational pass between the two registers.
// Reset: synchronous active-low aresetn empties both stages and sets max_year
// to 2020.
// ----------------------------------------------------------------------------
module date_check_and_day_difference #(
    parameter int YEAR_BITS = 14
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [13:0]            cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // year_a, month_a, day_a, hour_a, minute_a, second_a, year_b, month_b, day_b
    input  logic [((2 * YEAR_BITS + 42) / 8) * 8 - 1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // status, day_difference
    output logic [31:0]            m_tdata
);

    localparam int IN_BITS  = 2 * YEAR_BITS + 35;

    localparam int MA_LO = YEAR_BITS;
    localparam int DA_LO = MA_LO + 4;
    localparam int HH_LO = DA_LO + 5;
    localparam int MI_LO = HH_LO + 5;
    localparam int SS_LO = MI_LO + 6;
    localparam int YB_LO = SS_LO + 6;
    localparam int MB_LO = YB_LO + YEAR_BITS;
    localparam int DB_LO = MB_LO + 4;

    logic [dcdd_pkg::MAX_YEAR_BITS-1:0] max_year_reg;
    logic                               in_valid_reg;
    logic [IN_BITS-1:0]                 in_data_reg;
    logic                               out_valid_reg;
    logic [dcdd_pkg::STATUS_BITS-1:0]   status_reg;
    logic [dcdd_pkg::DIFF_BITS-1:0]     diff_reg;

    logic                               adv;
    logic [dcdd_pkg::STATUS_BITS-1:0]   status_next;
    logic [dcdd_pkg::DIFF_BITS-1:0]     diff_next;

    dcdd_pkg::year_t   ya, yb;
    logic [3:0]        ma, mb;
    logic [4:0]        da, db, hh;
    logic [5:0]        mi, ss;
    logic              zero_date, date_bad, time_bad;
    dcdd_pkg::ordinal_t oa, ob, day_gap;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv || !in_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, diff_reg, status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_year_reg <= dcdd_pkg::MAX_YEAR_RESET;
        end else if (cfg_wr_en) begin
            max_year_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata[IN_BITS-1:0];
        end
        if (adv && in_valid_reg) begin
            status_reg <= status_next;
            diff_reg   <= diff_next;
        end
    end

    always_comb begin
        ya = dcdd_pkg::CALC_YEAR_BITS'(in_data_reg[MA_LO-1:0]);
        ma = in_data_reg[DA_LO-1:MA_LO];
        da = in_data_reg[HH_LO-1:DA_LO];
        hh = in_data_reg[MI_LO-1:HH_LO];
        mi = in_data_reg[SS_LO-1:MI_LO];
        ss = in_data_reg[YB_LO-1:SS_LO];
        yb = dcdd_pkg::CALC_YEAR_BITS'(in_data_reg[MB_LO-1:YB_LO]);
        mb = in_data_reg[DB_LO-1:MB_LO];
        db = in_data_reg[IN_BITS-1:DB_LO];

        zero_date = (ya == '0) && (ma == 4'd0) && (da == 5'd0);
        date_bad  = !((ya <= dcdd_pkg::CALC_YEAR_BITS'(max_year_reg))
                      && (ma >= 4'd1) && (ma <= 4'd12) && (da >= 5'd1)
                      && (da <= dcdd_pkg::month_length(ma, ya)));
        time_bad  = !((hh <= dcdd_pkg::HOUR_MAX) && (mi <= dcdd_pkg::MINUTE_MAX)
                      && (ss <= dcdd_pkg::SECOND_MAX));

        oa      = dcdd_pkg::ordinal(ya, ma, da);
        ob      = dcdd_pkg::ordinal(yb, mb, db);
        day_gap = (oa > ob) ? (oa - ob) : (ob - oa);

        diff_next = '0;
        if (zero_date) begin
            status_next = dcdd_pkg::STATUS_ZERO_DATE;
        end else if (date_bad && time_bad) begin
            status_next = dcdd_pkg::STATUS_BOTH_ERR;
        end else if (date_bad) begin
            status_next = dcdd_pkg::STATUS_DATE_ERR;
        end else if (time_bad) begin
            status_next = dcdd_pkg::STATUS_TIME_ERR;
        end else begin
            status_next = dcdd_pkg::STATUS_VALID;
            if (day_gap > dcdd_pkg::ORD_BITS'(dcdd_pkg::DIFF_MAX)) begin
                diff_next = dcdd_pkg::DIFF_MAX;
            end else begin
                diff_next = day_gap[dcdd_pkg::DIFF_BITS-1:0];
            end
        end
    end

    a_err_no_diff: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (status_reg != dcdd_pkg::STATUS_VALID)) |-> (diff_reg == '0))
        else $error("nonzero day difference on an invalid date");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (status_reg <= dcdd_pkg::STATUS_ZERO_DATE))
        else $error("status code out of range");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full and stalled");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> in_valid_reg)
        else $error("accepted item lost from input stage");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for date_check_and_day_difference. Items go in on the
// s_ stream and results come back on the m_ stream, with random gaps and
// stalls on both sides. Each accepted item is scored against a calendar
// predictor kept in the bench, under several max_year settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [13:0] MAX_YEAR_AT_RESET = 14'd2020;
    localparam logic [13:0] YEAR_TOP          = 14'd16383;
    localparam int          DAYS_CEILING      = 4194303;
    localparam int          SETTLE_CYCLES     = 4;
    localparam int          WATCHDOG_LIMIT    = 2000;
    localparam int          SINK_HOLD_CYCLES  = 40;

    typedef struct packed {
        logic [13:0] year_a;
        logic [3:0]  month_a;
        logic [4:0]  day_a;
        logic [4:0]  hour_a;
        logic [5:0]  minute_a;
        logic [5:0]  second_a;
        logic [13:0] year_b;
        logic [3:0]  month_b;
        logic [4:0]  day_b;
    } date_item_t;

    typedef struct packed {
        dcdd_pkg::status_t status;
        logic [21:0]       days;
    } verdict_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [13:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    // year_a, month_a, day_a, hour_a, minute_a, second_a, year_b, month_b, day_b
    logic [63:0] s_tdata     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    // status, day_difference
    logic [31:0] m_tdata;

    verdict_t    pending_verdicts[$];
    logic [13:0] max_year_model  = MAX_YEAR_AT_RESET;
    logic [13:0] year_ceiling    = MAX_YEAR_AT_RESET;
    bit          source_idle_en  = 1'b1;
    bit          sink_idle_en    = 1'b1;
    int          sink_hold_req   = 0;
    int          error_count     = 0;
    int          results_checked = 0;
    int          saturated_count = 0;
    int          input_stalls    = 0;
    int          settings_used   = 1;
    int          idle_cycles     = 0;
    int          status_count[5] = '{default: 0};

    date_check_and_day_difference #(
        .YEAR_BITS (14)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // calendar predictor
    // ------------------------------------------------------------------
    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int m, input int y);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic int days_before(input int m);
        case (m)
            0, 1:    return 0;
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 365;
        endcase
    endfunction

    // day number counted from year 0; months past 12 count as a full year
    function automatic int day_number(input int y, input int m, input int d);
        int n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400
            + days_before(m) + d;
        if (m > 2 && leap_year(y)) begin
            n = n + 1;
        end
        return n;
    endfunction

    function automatic verdict_t date_verdict(input date_item_t it,
                                              input logic [13:0] ceiling);
        verdict_t v;
        bit       date_ok;
        bit       time_ok;
        int       gap;
        v.days = '0;
        if (it.year_a == 0 && it.month_a == 0 && it.day_a == 0) begin
            v.status = dcdd_pkg::STATUS_ZERO_DATE;
        end else begin
            date_ok = (it.year_a <= ceiling) && (it.month_a >= 1) && (it.month_a <= 12)
                      && (it.day_a >= 1)
                      && (int'(it.day_a) <= days_in_month(it.month_a, it.year_a));
            time_ok = (it.hour_a <= 23) && (it.minute_a <= 59) && (it.second_a <= 59);
            if (date_ok && time_ok) begin
                v.status = dcdd_pkg::STATUS_VALID;
                gap = day_number(it.year_a, it.month_a, it.day_a)
                      - day_number(it.year_b, it.month_b, it.day_b);
                if (gap < 0) begin
                    gap = -gap;
                end
                if (gap > DAYS_CEILING) begin
                    gap = DAYS_CEILING;
                end
                v.days = 22'(gap);
            end else if (time_ok) begin
                v.status = dcdd_pkg::STATUS_DATE_ERR;
            end else if (date_ok) begin
                v.status = dcdd_pkg::STATUS_TIME_ERR;
            end else begin
                v.status = dcdd_pkg::STATUS_BOTH_ERR;
            end
        end
        return v;
    endfunction

    function automatic logic [63:0] pack_item(input date_item_t it);
        return {1'b0, it.day_b, it.month_b, it.year_b, it.second_a, it.minute_a,
                it.hour_a, it.day_a, it.month_a, it.year_a};
    endfunction

    function automatic date_item_t unpack_item(input logic [63:0] bits);
        date_item_t it;
        it.year_a   = bits[13:0];
        it.month_a  = bits[17:14];
        it.day_a    = bits[22:18];
        it.hour_a   = bits[27:23];
        it.minute_a = bits[33:28];
        it.second_a = bits[39:34];
        it.year_b   = bits[53:40];
        it.month_b  = bits[57:54];
        it.day_b    = bits[62:58];
        return it;
    endfunction

    function automatic date_item_t mk(input int ya, input int ma, input int da,
                                      input int hh, input int mi, input int ss,
                                      input int yb, input int mb, input int db);
        date_item_t it;
        it.year_a   = 14'(ya);
        it.month_a  = 4'(ma);
        it.day_a    = 5'(da);
        it.hour_a   = 5'(hh);
        it.minute_a = 6'(mi);
        it.second_a = 6'(ss);
        it.year_b   = 14'(yb);
        it.month_b  = 4'(mb);
        it.day_b    = 5'(db);
        return it;
    endfunction

    // mostly well-formed dates with random content, the rest noise
    function automatic date_item_t random_item(input int ceiling);
        date_item_t it;
        int         pick;
        int         step;
        pick        = $urandom_range(0, 99);
        it.year_a   = 14'($urandom_range(0, ceiling));
        it.month_a  = 4'($urandom_range(1, 12));
        it.day_a    = 5'($urandom_range(1, days_in_month(it.month_a, it.year_a)));
        it.hour_a   = 5'($urandom_range(0, 23));
        it.minute_a = 6'($urandom_range(0, 59));
        it.second_a = 6'($urandom_range(0, 59));
        it.year_b   = 14'($urandom_range(0, 16383));
        if ($urandom_range(0, 99) < 85) begin
            it.month_b = 4'($urandom_range(1, 12));
            it.day_b   = 5'($urandom_range(1, 31));
        end else begin
            it.month_b = 4'($urandom_range(0, 15));
            it.day_b   = 5'($urandom_range(0, 31));
        end
        if (pick < 8) begin
            it.year_b  = it.year_a;
            it.month_b = it.month_a;
            it.day_b   = it.day_a;
        end else if (pick < 55) begin
        end else if (pick < 65) begin
            step       = $urandom_range(0, 2);
            it.month_a = 4'd2;
            it.day_a   = 5'($urandom_range(28, 29));
            case (step)
                0:       it.year_a = 14'(4 * $urandom_range(0, 4095));
                1:       it.year_a = 14'(100 * $urandom_range(0, 163));
                default: it.year_a = 14'(400 * $urandom_range(0, 40));
            endcase
        end else if (pick < 72) begin
            it.year_a = 14'(ceiling + $urandom_range(0, (ceiling < 16383) ? 1 : 0));
            it.month_a = 4'd12;
            it.day_a   = 5'd31;
        end else if (pick < 80) begin
            it.hour_a   = 5'($urandom_range(0, 31));
            it.minute_a = 6'($urandom_range(0, 63));
            it.second_a = 6'($urandom_range(0, 63));
        end else if (pick < 95) begin
            it = date_item_t'(63'({$urandom(), $urandom()}));
        end else begin
            it.year_a   = '0;
            it.month_a  = '0;
            it.day_a    = '0;
            it.hour_a   = 5'($urandom_range(0, 31));
            it.minute_a = 6'($urandom_range(0, 63));
            it.second_a = 6'($urandom_range(0, 63));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // stream drivers
    // ------------------------------------------------------------------
    task automatic send_item(input date_item_t it);
        int gap;
        gap = source_idle_en ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic finish_burst();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_max_year(input logic [13:0] value);
        finish_burst();
        cfg_wr_en    <= 1'b1;
        cfg_wr_data  <= value;
        year_ceiling  = value;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        settings_used++;
    endtask

    initial begin : result_sink
        int stall;
        wait (aresetn);
        forever begin
            if (sink_hold_req > 0) begin
                stall = sink_hold_req;
            end else begin
                stall = sink_idle_en ? $urandom_range(0, 3) : 0;
            end
            sink_hold_req = 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------
    // scoreboard and watchdog
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        verdict_t    want;
        logic [2:0]  got_status;
        logic [21:0] got_days;
        if (aresetn) begin
            if (cfg_wr_en) begin
                max_year_model = cfg_wr_data;
            end
            if (s_tvalid && !s_tready) begin
                input_stalls++;
            end
            if (s_tvalid && s_tready) begin
                want = date_verdict(unpack_item(s_tdata), max_year_model);
                pending_verdicts.push_back(want);
                status_count[int'(want.status)]++;
                if (want.days == 22'(DAYS_CEILING)) begin
                    saturated_count++;
                end
            end
            if (m_tvalid && m_tready) begin
                got_status = m_tdata[2:0];
                got_days   = m_tdata[24:3];
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: unexpected result: status %0d, days %0d",
                             $time, got_status, got_days);
                    error_count++;
                end else begin
                    want = pending_verdicts.pop_front();
                    results_checked++;
                    if (got_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, got_status);
                        error_count++;
                    end
                    if (got_days !== want.days) begin
                        $display("%0t: day_difference mismatch: expected %0d, actual %0d",
                                 $time, want.days, got_days);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     pending_verdicts.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_year_limit();
        send_item(mk(2020, 12, 31, 12, 0, 0, 2020, 1, 1));
        send_item(mk(2021, 1, 1, 0, 0, 0, 2020, 1, 1));
        finish_burst();
    endtask

    task automatic test_calendar_corners();
        send_item(mk(0, 0, 0, 31, 63, 63, 1, 1, 1));
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 1, 1));
        send_item(mk(0, 0, 1, 0, 0, 0, 0, 1, 1));
        send_item(mk(0, 1, 0, 0, 0, 0, 0, 1, 1));
        send_item(mk(0, 1, 1, 0, 0, 0, 2020, 6, 15));
        send_item(mk(2000, 2, 29, 23, 59, 59, 1, 1, 1));
        send_item(mk(1900, 2, 29, 0, 0, 0, 1, 1, 1));
        send_item(mk(2019, 2, 29, 0, 0, 0, 2016, 2, 29));
        send_item(mk(2016, 2, 29, 0, 0, 0, 2019, 3, 1));
        send_item(mk(2019, 4, 31, 0, 0, 0, 2019, 1, 1));
        send_item(mk(2019, 4, 30, 0, 0, 0, 2019, 1, 1));
        send_item(mk(2019, 13, 1, 0, 0, 0, 2019, 1, 1));
        send_item(mk(2019, 15, 31, 0, 0, 0, 2019, 1, 1));
        send_item(mk(2019, 6, 1, 24, 0, 0, 2019, 1, 1));
        send_item(mk(2019, 6, 1, 0, 60, 0, 2019, 1, 1));
        send_item(mk(2019, 6, 1, 0, 0, 60, 2019, 1, 1));
        send_item(mk(2019, 0, 5, 31, 63, 63, 2019, 1, 1));
        // date B outside the calendar
        send_item(mk(2019, 6, 1, 0, 0, 0, 2016, 0, 0));
        send_item(mk(2019, 6, 1, 0, 0, 0, 2016, 13, 31));
        send_item(mk(2019, 6, 1, 0, 0, 0, 16383, 15, 31));
        finish_burst();
    endtask

    task automatic test_year_limit_extremes();
        set_max_year(14'd0);
        send_item(mk(0, 2, 29, 0, 0, 0, 0, 1, 1));
        send_item(mk(1, 1, 1, 0, 0, 0, 0, 1, 1));
        set_max_year(YEAR_TOP);
        send_item(mk(16383, 12, 31, 23, 59, 59, 0, 1, 1));
        send_item(mk(16383, 15, 31, 31, 63, 63, 16383, 15, 31));
        finish_burst();
    endtask

    task automatic test_random_dates();
        logic [13:0] limits[5];
        limits = '{14'($urandom_range(1, 16382)), 14'd0, YEAR_TOP, 14'd9999,
                   MAX_YEAR_AT_RESET};
        foreach (limits[p]) begin
            set_max_year(limits[p]);
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) begin
                    source_idle_en = ($urandom_range(0, 3) != 0);
                    sink_idle_en   = ($urandom_range(0, 3) != 0);
                end
                send_item(random_item(year_ceiling));
            end
        end
        finish_burst();
        source_idle_en = 1'b1;
        sink_idle_en   = 1'b1;
    endtask

    task automatic test_output_backpressure();
        source_idle_en = 1'b0;
        sink_hold_req  = SINK_HOLD_CYCLES;
        for (int n = 0; n < 40; n++) begin
            send_item(random_item(year_ceiling));
        end
        finish_burst();
        source_idle_en = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_year_limit();
        test_calendar_corners();
        test_year_limit_extremes();
        test_random_dates();
        test_output_backpressure();
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
            error_count++;
        end
        $display("Checked %0d results under %0d max_year settings: %0d valid, %0d date err,",
                 results_checked, settings_used, status_count[0], status_count[1]);
        $display("%0d time err, %0d both, %0d all-zero, %0d saturated, %0d input stall cycles",
                 status_count[2], status_count[3], status_count[4], saturated_count,
                 input_stalls);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: date_check_and_day_difference.f
hw/rtl/dcdd_pkg.sv
hw/rtl/date_check_and_day_difference.sv
tb/tb_top.sv
